// ===== hdl/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Shared field widths, request and status codes, and the control and status
// bundles passed between the controller and the datapath of cursor_array_list.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int MODE_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int POS_W    = 10;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic [MODE_W-1:0] MODE_READ_CUR   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PREV       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_START      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_END        = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_READ_IDX   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_WRITE_IDX  = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic load_req;
        logic read_issue;
        logic shift_init;
        logic shift_step;
        logic shift_drain;
        logic commit;
    } cal_cmd_t;

    typedef struct packed {
        logic do_shift;
        logic rem_zero;
    } cal_stat_t;

endpackage

// ===== hdl/cursor_array_list.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list
// Array-backed ordered list with element count and cursor; one result
// transaction per request transaction.
// ----------------------------------------------------------------------------
// Sequencing: a request is accepted only in IDLE, so a new request is not
//   taken until the previous result is committed; insert and delete shift
//   n elements (up to CAPACITY - 1), one element per cycle through the
//   single memory port pair.
// Reset: count and cursor return to zero; element memory is not cleared.
// ----------------------------------------------------------------------------
module cursor_array_list #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cal_pkg::S_TDATA_W-1:0]     s_tdata,  // mode, value, index
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cal_pkg::M_TDATA_W-1:0]     m_tdata   // data, moved, status, count, position
);

    cal_pkg::cal_cmd_t  cmd;
    cal_pkg::cal_stat_t stat;

    logic [cal_pkg::DATA_W-1:0]   out_data;
    logic                         out_moved;
    logic [cal_pkg::STATUS_W-1:0] out_status;
    logic [cal_pkg::COUNT_W-1:0]  out_count;
    logic [cal_pkg::POS_W-1:0]    out_position;

    cal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cal_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_mode      (s_tdata[3:0]),
        .in_value     (s_tdata[35:4]),
        .in_index     (s_tdata[45:36]),
        .out_data     (out_data),
        .out_moved    (out_moved),
        .out_status   (out_status),
        .out_count    (out_count),
        .out_position (out_position)
    );

    assign m_tdata = {out_position, out_count, out_status, out_moved, out_data};

endmodule

// ===== hdl/cal_ctrl.sv =====
// ----------------------------------------------------------------------------
// cal_ctrl
// Request sequencer: decode, element shift loop, commit and result handoff.
// ----------------------------------------------------------------------------
module cal_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  cal_pkg::cal_stat_t stat,
    output cal_pkg::cal_cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE,
        DECODE,
        SHIFT,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = DECODE;
                end
            end
            DECODE: begin
                cmd.read_issue = 1'b1;
                if (stat.do_shift) begin
                    cmd.shift_init = 1'b1;
                    state_next     = SHIFT;
                end else begin
                    state_next = FINISH;
                end
            end
            SHIFT: begin
                if (!stat.rem_zero) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.shift_drain = 1'b1;
                    state_next      = FINISH;
                end
            end
            FINISH: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/cal_datapath.sv =====
// ----------------------------------------------------------------------------
// cal_datapath
// Element memory, count and cursor registers, request decode, shift pointer
// and result register.
// ----------------------------------------------------------------------------
module cal_datapath #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cal_pkg::cal_cmd_t                 cmd,
    output cal_pkg::cal_stat_t                stat,
    input  logic [cal_pkg::MODE_W-1:0]        in_mode,
    input  logic [cal_pkg::VALUE_W-1:0]       in_value,
    input  logic [cal_pkg::INDEX_W-1:0]       in_index,
    output logic [cal_pkg::DATA_W-1:0]        out_data,
    output logic                              out_moved,
    output logic [cal_pkg::STATUS_W-1:0]      out_status,
    output logic [cal_pkg::COUNT_W-1:0]       out_count,
    output logic [cal_pkg::POS_W-1:0]         out_position
);

    localparam int PW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = (CW > cal_pkg::INDEX_W) ? CW : cal_pkg::INDEX_W;
    localparam int DW   = DATA_WIDTH;
    localparam int ODW  = cal_pkg::DATA_W;
    localparam int OCW  = cal_pkg::COUNT_W;
    localparam int OPW  = cal_pkg::POS_W;

    logic [DW-1:0] mem [CAPACITY];

    logic [cal_pkg::MODE_W-1:0]  req_mode_reg;
    logic [DW-1:0]               req_value_reg;
    logic [cal_pkg::INDEX_W-1:0] req_index_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] dst_reg, dst_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          pend_reg, pend_next;
    logic [DW-1:0] rdata_reg;

    logic [ODW-1:0]               data_reg;
    logic                         moved_reg;
    logic [cal_pkg::STATUS_W-1:0] status_reg;
    logic [OCW-1:0]               ocount_reg;
    logic [OPW-1:0]               opos_reg;

    logic                         empty, full, in_range, is_del, is_ins, is_rd;
    logic [CW-1:0]                cur_c, cur_inc, slot;
    logic [cal_pkg::STATUS_W-1:0] status;
    logic                         moved;
    logic                         rd_en, wr_en;
    logic [PW-1:0]                rd_addr, wr_addr;
    logic [DW-1:0]                wr_data;

    always_comb begin
        empty    = (count_reg == '0);
        full     = (count_reg >= CW'(CAPACITY));
        in_range = (XW'(req_index_reg) < XW'(count_reg));
        cur_c    = CW'(cursor_reg);
        cur_inc  = cur_c + CW'(1);
        is_del   = (req_mode_reg == cal_pkg::MODE_DELETE);
        is_ins   = (req_mode_reg inside {cal_pkg::MODE_INS_BEFORE, cal_pkg::MODE_INS_AFTER});
        slot     = (req_mode_reg == cal_pkg::MODE_INS_BEFORE) ? cur_c : cur_inc;

        status = cal_pkg::ST_OK;
        if (req_mode_reg <= cal_pkg::MODE_DELETE && empty) begin
            status = cal_pkg::ST_EMPTY;
        end else if (is_ins && full) begin
            status = cal_pkg::ST_FULL;
        end else if ((req_mode_reg inside {cal_pkg::MODE_READ_IDX, cal_pkg::MODE_WRITE_IDX})
                     && !in_range) begin
            status = cal_pkg::ST_RANGE;
        end

        is_rd = (status == cal_pkg::ST_OK) &&
                (req_mode_reg inside {cal_pkg::MODE_READ_CUR, cal_pkg::MODE_READ_IDX});

        moved = 1'b0;
        if (status == cal_pkg::ST_OK) begin
            if (req_mode_reg == cal_pkg::MODE_PREV) begin
                moved = (cursor_reg != '0);
            end else if (req_mode_reg == cal_pkg::MODE_NEXT) begin
                moved = (cur_inc < count_reg);
            end
        end

        stat.do_shift = (status == cal_pkg::ST_OK) && (is_del || (is_ins && !empty));
        stat.rem_zero = (rem_reg == '0);
    end

    always_comb begin
        ptr_next = ptr_reg;
        dst_next = dst_reg;
        rem_next = rem_reg;
        pend_next = pend_reg;
        if (cmd.shift_init) begin
            pend_next = 1'b0;
            if (is_del) begin
                ptr_next = PW'(cur_inc);
                rem_next = count_reg - cur_inc;
            end else begin
                ptr_next = PW'(count_reg - CW'(1));
                rem_next = count_reg - slot;
            end
        end else if (cmd.shift_step) begin
            pend_next = 1'b1;
            rem_next  = rem_reg - CW'(1);
            if (is_del) begin
                ptr_next = ptr_reg + PW'(1);
                dst_next = ptr_reg - PW'(1);
            end else begin
                ptr_next = ptr_reg - PW'(1);
                dst_next = ptr_reg + PW'(1);
            end
        end else if (cmd.shift_drain) begin
            pend_next = 1'b0;
        end
    end

    always_comb begin
        rd_en   = cmd.read_issue || cmd.shift_step;
        rd_addr = cmd.shift_step ? ptr_reg :
                  (req_mode_reg == cal_pkg::MODE_READ_CUR) ? cursor_reg :
                  PW'(req_index_reg);

        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = rdata_reg;
        if ((cmd.shift_step || cmd.shift_drain) && pend_reg) begin
            wr_en = 1'b1;
        end else if (cmd.commit && status == cal_pkg::ST_OK) begin
            if (is_ins) begin
                wr_en   = 1'b1;
                wr_addr = empty ? '0 : PW'(slot);
                wr_data = req_value_reg;
            end else if (req_mode_reg == cal_pkg::MODE_WRITE_IDX) begin
                wr_en   = 1'b1;
                wr_addr = PW'(req_index_reg);
                wr_data = req_value_reg;
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        if (status == cal_pkg::ST_OK) begin
            case (req_mode_reg)
                cal_pkg::MODE_PREV: begin
                    if (moved) begin
                        cursor_next = cursor_reg - PW'(1);
                    end
                end
                cal_pkg::MODE_NEXT: begin
                    if (moved) begin
                        cursor_next = cursor_reg + PW'(1);
                    end
                end
                cal_pkg::MODE_START: begin
                    cursor_next = '0;
                end
                cal_pkg::MODE_END: begin
                    cursor_next = PW'(count_reg - CW'(1));
                end
                cal_pkg::MODE_DELETE: begin
                    count_next = count_reg - CW'(1);
                    if (cur_inc == count_reg && count_reg > CW'(1)) begin
                        cursor_next = cursor_reg - PW'(1);
                    end
                end
                cal_pkg::MODE_INS_BEFORE: begin
                    count_next = count_reg + CW'(1);
                    if (!empty) begin
                        cursor_next = PW'(cur_inc);
                    end
                end
                cal_pkg::MODE_INS_AFTER: begin
                    count_next = count_reg + CW'(1);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_mode_reg  <= in_mode;
            req_value_reg <= DW'(in_value);
            req_index_reg <= in_index;
        end
        ptr_reg <= ptr_next;
        dst_reg <= dst_next;
        rem_reg <= rem_next;
        if (cmd.commit) begin
            data_reg   <= is_rd ? ODW'(rdata_reg) : '0;
            moved_reg  <= moved;
            status_reg <= status;
            ocount_reg <= OCW'(count_next);
            opos_reg   <= OPW'(cursor_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (cmd.commit) begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    assign out_data     = data_reg;
    assign out_moved    = moved_reg;
    assign out_status   = status_reg;
    assign out_count    = ocount_reg;
    assign out_position = opos_reg;

endmodule

// ===== test/cursor_array_list_chk.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list_chk
// Watches the request and result streams of cursor_array_list, keeps its own
// copy of the element store, count and cursor, predicts one result per
// accepted request and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module cursor_array_list_chk #(
    parameter int CAPACITY = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cal_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cal_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [cal_pkg::DATA_W-1:0]   data;
        logic                         moved;
        logic [cal_pkg::STATUS_W-1:0] status;
        logic [cal_pkg::COUNT_W-1:0]  count;
        logic [cal_pkg::POS_W-1:0]    position;
    } list_result_t;

    logic [cal_pkg::DATA_W-1:0] elements [CAPACITY];
    int                         fill;
    int                         cur;
    list_result_t               awaited_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        fill        = 0;
        cur         = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic list_result_t list_apply(
        input logic [cal_pkg::MODE_W-1:0]  mode,
        input logic [cal_pkg::VALUE_W-1:0] value,
        input logic [cal_pkg::INDEX_W-1:0] index
    );
        list_result_t r;
        int           i;
        int           slot;
        r = '{default: '0};
        if (mode <= cal_pkg::MODE_DELETE && fill == 0) begin
            r.status = cal_pkg::ST_EMPTY;
        end else begin
            case (mode)
                cal_pkg::MODE_READ_CUR: r.data = elements[cur];
                cal_pkg::MODE_PREV: begin
                    if (cur != 0) begin
                        cur--;
                        r.moved = 1'b1;
                    end
                end
                cal_pkg::MODE_NEXT: begin
                    if (cur + 1 < fill) begin
                        cur++;
                        r.moved = 1'b1;
                    end
                end
                cal_pkg::MODE_START: cur = 0;
                cal_pkg::MODE_END:   cur = fill - 1;
                cal_pkg::MODE_DELETE: begin
                    for (i = cur; i + 1 < fill; i++)
                        elements[i] = elements[i + 1];
                    if (cur + 1 == fill && fill > 1)
                        cur--;
                    fill--;
                end
                cal_pkg::MODE_INS_BEFORE, cal_pkg::MODE_INS_AFTER: begin
                    if (fill >= CAPACITY) begin
                        r.status = cal_pkg::ST_FULL;
                    end else if (fill == 0) begin
                        elements[0] = value;
                        cur  = 0;
                        fill = 1;
                    end else begin
                        slot = (mode == cal_pkg::MODE_INS_BEFORE) ? cur : cur + 1;
                        for (i = fill; i > slot; i--)
                            elements[i] = elements[i - 1];
                        elements[slot] = value;
                        if (mode == cal_pkg::MODE_INS_BEFORE)
                            cur++;
                        fill++;
                    end
                end
                cal_pkg::MODE_READ_IDX, cal_pkg::MODE_WRITE_IDX: begin
                    if (int'(index) >= fill)
                        r.status = cal_pkg::ST_RANGE;
                    else if (mode == cal_pkg::MODE_READ_IDX)
                        r.data = elements[index];
                    else
                        elements[index] = value;
                end
                default: ;
            endcase
        end
        r.count    = cal_pkg::COUNT_W'(fill);
        r.position = cal_pkg::POS_W'(cur);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t                 want;
        logic [cal_pkg::DATA_W-1:0]   got_data;
        logic                         got_moved;
        logic [cal_pkg::STATUS_W-1:0] got_status;
        logic [cal_pkg::COUNT_W-1:0]  got_count;
        logic [cal_pkg::POS_W-1:0]    got_position;
        if (!aresetn) begin
            fill = 0;
            cur  = 0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_data     = m_tdata[0 +: cal_pkg::DATA_W];
                got_moved    = m_tdata[cal_pkg::DATA_W];
                got_status   = m_tdata[cal_pkg::DATA_W + 1 +: cal_pkg::STATUS_W];
                got_count    = m_tdata[cal_pkg::DATA_W + 1 + cal_pkg::STATUS_W +:
                                       cal_pkg::COUNT_W];
                got_position = m_tdata[cal_pkg::DATA_W + 1 + cal_pkg::STATUS_W +
                                       cal_pkg::COUNT_W +: cal_pkg::POS_W];
                if (awaited_results.size() == 0) begin
                    report("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got_data !== want.data)
                        report("data", got_data, want.data);
                    if (got_moved !== want.moved)
                        report("moved", got_moved, want.moved);
                    if (got_status !== want.status)
                        report("status", got_status, want.status);
                    if (got_count !== want.count)
                        report("count", got_count, want.count);
                    if (got_position !== want.position)
                        report("position", got_position, want.position);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(list_apply(
                    s_tdata[0 +: cal_pkg::MODE_W],
                    s_tdata[cal_pkg::MODE_W +: cal_pkg::VALUE_W],
                    s_tdata[cal_pkg::MODE_W + cal_pkg::VALUE_W +: cal_pkg::INDEX_W]));
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== test/cursor_array_list_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list_tb
// Drives request transactions into cursor_array_list with random gaps and
// result back-pressure: directed corner cases on an empty and a short list,
// then random requests on short lists. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module cursor_array_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cal_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cal_pkg::M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int fill_level;
    bit no_idle;
    bit stall_req;

    cursor_array_list #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (cal_pkg::DATA_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cursor_array_list_chk #(
        .CAPACITY (CAPACITY)
    ) chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("cursor_array_list_tb: errors");
        $finish;
    end

    initial begin
        int gap;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (stall_req) begin
                gap       = 400;
                stall_req = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic issue(input logic [cal_pkg::MODE_W-1:0]  mode,
                         input logic [cal_pkg::VALUE_W-1:0] value = '0,
                         input logic [cal_pkg::INDEX_W-1:0] index = '0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cal_pkg::S_TDATA_W - cal_pkg::MODE_W - cal_pkg::VALUE_W -
                       cal_pkg::INDEX_W){1'b0}}, index, value, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if ((mode == cal_pkg::MODE_INS_BEFORE || mode == cal_pkg::MODE_INS_AFTER) &&
            fill_level < CAPACITY)
            fill_level++;
        else if (mode == cal_pkg::MODE_DELETE && fill_level > 0)
            fill_level--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [cal_pkg::INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && fill_level > 0)
            return cal_pkg::INDEX_W'($urandom_range(0, fill_level - 1));
        else if (r < 85)
            return cal_pkg::INDEX_W'(fill_level);
        return cal_pkg::INDEX_W'($urandom_range(0, 1023));
    endfunction

    initial begin
        int r;
        logic [cal_pkg::MODE_W-1:0] mode;
        fill_level = 0;
        no_idle    = 1'b0;
        stall_req  = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list
        issue(cal_pkg::MODE_READ_CUR);
        issue(cal_pkg::MODE_PREV);
        issue(cal_pkg::MODE_NEXT);
        issue(cal_pkg::MODE_START);
        issue(cal_pkg::MODE_END);
        issue(cal_pkg::MODE_DELETE);
        issue(cal_pkg::MODE_READ_IDX, '0, '0);
        issue(cal_pkg::MODE_WRITE_IDX, 32'h1234_5678, '0);
        issue(4'd10);
        issue(4'd15, '1, '1);
        // short list
        issue(cal_pkg::MODE_INS_BEFORE, 32'hFFFF_FFFF);
        issue(cal_pkg::MODE_INS_AFTER, 32'h0000_0000);
        issue(cal_pkg::MODE_INS_BEFORE, 32'hA5A5_5A5A);
        issue(cal_pkg::MODE_PREV);
        issue(cal_pkg::MODE_PREV);
        issue(cal_pkg::MODE_NEXT);
        issue(cal_pkg::MODE_NEXT);
        issue(cal_pkg::MODE_NEXT);
        issue(cal_pkg::MODE_READ_CUR);
        issue(cal_pkg::MODE_WRITE_IDX, 32'h8000_0001, 10'd1);
        issue(cal_pkg::MODE_READ_IDX, '0, 10'd1);
        issue(cal_pkg::MODE_READ_IDX, '0, 10'd3);
        issue(cal_pkg::MODE_DELETE);
        issue(cal_pkg::MODE_START);
        issue(cal_pkg::MODE_DELETE);

        wait_drained();

        for (int n = 0; n < 555; n++) begin
            if (n == 150)
                stall_req = 1'b1;
            no_idle = (n >= 300 && n < 380);
            if (n == 400)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 16)
                mode = (fill_level < 40) ? ($urandom_range(0, 1) ? cal_pkg::MODE_INS_BEFORE
                                                                  : cal_pkg::MODE_INS_AFTER)
                                         : cal_pkg::MODE_DELETE;
            else if (r < 26)
                mode = cal_pkg::MODE_DELETE;
            else if (r < 35)
                mode = cal_pkg::MODE_READ_CUR;
            else if (r < 44)
                mode = cal_pkg::MODE_PREV;
            else if (r < 53)
                mode = cal_pkg::MODE_NEXT;
            else if (r < 58)
                mode = cal_pkg::MODE_START;
            else if (r < 63)
                mode = cal_pkg::MODE_END;
            else if (r < 76)
                mode = cal_pkg::MODE_READ_IDX;
            else if (r < 90)
                mode = cal_pkg::MODE_WRITE_IDX;
            else
                mode = cal_pkg::MODE_W'($urandom_range(10, 15));
            issue(mode, $urandom, pick_index());
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("cursor_array_list_tb: clean");
        end else begin
            $display("cursor_array_list_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cal_pkg.sv
hdl/cal_ctrl.sv
hdl/cal_datapath.sv
hdl/cursor_array_list.sv
test/cursor_array_list_chk.sv
test/cursor_array_list_tb.sv
